[rtl/two_worker_layer_task_dispatcher_defines.svh]
// Assertion macros for the two-worker layer task dispatcher.
// Included by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef TWO_WORKER_LAYER_TASK_DISPATCHER_DEFINES_SVH
`define TWO_WORKER_LAYER_TASK_DISPATCHER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled in reset.
`define TWLTD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled in reset.
`define TWLTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TWLTD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define TWLTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/twltd_pkg.sv]
// Shared types, codes and default sizes of the two-worker layer task dispatcher.
// Used by every module of the block but twltd_ram; depends on nothing.
package twltd_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int JOB_COUNT_DEF   = 64;
   localparam int MAX_LAYERS_DEF  = 64;
   localparam int SLOT_COUNT_DEF  = 10;

   // Layer counts and layer indexes are carried in this many bits.
   localparam int LAYER_W = 7;

   localparam logic [7:0] THRESHOLD_RESET = 8'd20;
   localparam logic [7:0] IDLE_MAX        = 8'd255;

   // Register indexes, taken from address bit 2.
   localparam logic REG_POLICY    = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;

   // Owner codes of a job entry.
   localparam logic [1:0] OWNER_NONE = 2'd0;
   localparam logic [1:0] OWNER_W0   = 2'd1;
   localparam logic [1:0] OWNER_W1   = 2'd2;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_ARRIVAL = 2'd1,
      OP_DONE    = 2'd2,
      OP_SLOT    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_DISPATCH = 2'd0,
      KIND_REFILL   = 2'd1,
      KIND_DROP     = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      POL_ADAPTIVE  = 3'd0,
      POL_LAYERWISE = 3'd1,
      POL_AFFINITY  = 3'd2,
      POL_FIXED     = 3'd3,
      POL_PARITY    = 3'd4
   } policy_type;

   typedef struct packed {
      kind_type   kind;
      logic       to_worker;
      logic [5:0] job;
      logic [5:0] layer;
      logic [3:0] slot;
      logic       slot_ok;
   } result_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic ev_read;
      logic ev_exec;
      logic sch_init;
      logic q_read;
      logic j0_read;
      logic j1_read;
      logic w_exec;
      logic worker;
      logic drain;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       any_queued;
      logic [1:0] busy;
      logic       drain_done;
   } status_type;

endpackage

[rtl/twltd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the task queues and the job table; depends on nothing.
module twltd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and a read port whose data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/twltd_csr.sv]
// Configuration registers of the dispatcher behind an APB-style port.
// Uses twltd_pkg for register indexes and reset values.
module twltd_csr
   import twltd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [2:0]  policy_mode,
   output logic [7:0]  idle_threshold
);

   logic [2:0] policy_ff;
   logic [7:0] threshold_ff;
   logic       wr_go;

   assign wr_go = csr_psel && csr_penable && csr_pwrite;

   // Register writes in the access phase of a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POL_ADAPTIVE;
         threshold_ff <= THRESHOLD_RESET;
      end else if (wr_go) begin
         case (csr_paddr[2])
            REG_POLICY:    policy_ff    <= csr_pwdata[2:0];
            REG_THRESHOLD: threshold_ff <= csr_pwdata[7:0];
            default:       policy_ff    <= policy_ff;
         endcase
      end
   end

   // Read data selection.
   always_comb begin
      case (csr_paddr[2])
         REG_POLICY:    csr_prdata = {29'd0, policy_ff};
         REG_THRESHOLD: csr_prdata = {24'd0, threshold_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready     = 1'b1;
   assign policy_mode    = policy_ff;
   assign idle_threshold = threshold_ff;

endmodule

[rtl/twltd_ctrl.sv]
// Controller state machine of the dispatcher: sequences event, scheduling and drain steps.
// Uses twltd_pkg for the command and status structs.
module twltd_ctrl
   import twltd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EV_RD,
      ST_EV_EX,
      ST_SCHED,
      ST_PICK,
      ST_Q_RD,
      ST_J0_RD,
      ST_J1_RD,
      ST_W_EX,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   logic      worker_ff;

   // State and worker index.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         worker_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE:  if (req_valid) state_ff <= ST_EV_RD;
            ST_EV_RD: state_ff <= ST_EV_EX;
            ST_EV_EX: state_ff <= ST_SCHED;
            ST_SCHED: begin
               worker_ff <= 1'b0;
               state_ff  <= status.any_queued ? ST_PICK : ST_DRAIN;
            end
            ST_PICK: begin
               if (!status.busy[worker_ff]) begin
                  state_ff <= ST_Q_RD;
               end else if (worker_ff) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  worker_ff <= 1'b1;
               end
            end
            ST_Q_RD:  state_ff <= ST_J0_RD;
            ST_J0_RD: state_ff <= ST_J1_RD;
            ST_J1_RD: state_ff <= ST_W_EX;
            ST_W_EX: begin
               if (worker_ff) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  worker_ff <= 1'b1;
                  state_ff  <= ST_PICK;
               end
            end
            ST_DRAIN: if (status.drain_done) state_ff <= ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   // Command decode.
   always_comb begin
      cmd          = '0;
      cmd.worker   = worker_ff;
      cmd.accept   = (state_ff == ST_IDLE) && req_valid;
      cmd.ev_read  = (state_ff == ST_EV_RD);
      cmd.ev_exec  = (state_ff == ST_EV_EX);
      cmd.sch_init = (state_ff == ST_SCHED) && status.any_queued;
      cmd.q_read   = (state_ff == ST_Q_RD);
      cmd.j0_read  = (state_ff == ST_J0_RD);
      cmd.j1_read  = (state_ff == ST_J1_RD);
      cmd.w_exec   = (state_ff == ST_W_EX);
      cmd.drain    = (state_ff == ST_DRAIN);
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

[rtl/twltd_dpath.sv]
// Datapath of the dispatcher: queues, job table, worker and slot state, result buffer.
// Uses twltd_pkg, twltd_ram and the assertion macros of the defines header.
`include "two_worker_layer_task_dispatcher_defines.svh"
module twltd_dpath
   import twltd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int JOB_COUNT   = JOB_COUNT_DEF,
   parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
   parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic [1:0] req_operation,
   input  logic [5:0] req_job_handle,
   input  logic       req_model_sel,
   input  logic [6:0] req_layer_total,
   input  logic       req_done_worker,
   input  logic [5:0] req_done_layer,
   input  logic [3:0] req_ready_slot,
   input  logic [2:0] policy_mode,
   input  logic [7:0] idle_threshold,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [1:0] rsp_kind,
   output logic       rsp_to_worker,
   output logic [5:0] rsp_out_job,
   output logic [5:0] rsp_out_layer,
   output logic [3:0] rsp_out_slot,
   output logic       rsp_slot_ok,
   output logic       rsp_last
);

   localparam int QAW  = $clog2(QUEUE_DEPTH);
   localparam int CW   = QAW + 1;
   localparam int JIW  = $clog2(JOB_COUNT);
   localparam int SIW  = $clog2(SLOT_COUNT);
   localparam int HALF = SLOT_COUNT / 2;
   localparam logic [CW-1:0] QD_C = CW'(QUEUE_DEPTH);

   typedef struct packed {
      logic [LAYER_W-1:0] layers;
      logic               model;
      logic [1:0]         owner;
      logic [SIW-1:0]     slot;
      logic               slot_ok;
   } job_entry_type;

   typedef struct packed {
      logic [JIW-1:0]     job;
      logic [LAYER_W-1:0] layer;
   } queue_entry_type;

   // Job handle folded into the table, as a constant table over the six handle bits.
   function automatic logic [JIW-1:0] job_index(input logic [5:0] h);
      logic [JIW-1:0] r;
      r = '0;
      for (int k = 0; k < 64; k++) begin
         if (h == 6'(k)) r = JIW'(k % JOB_COUNT);
      end
      return r;
   endfunction

   // Event registers.
   op_type             op_ff, op_in;
   logic [JIW-1:0]     job_ff, job_in;
   logic               msel_ff, msel_in;
   logic [6:0]         total_ff, total_in;
   logic               dw_ff, dw_in;
   logic [5:0]         dl_ff, dl_in;
   logic [3:0]         rs_ff, rs_in;

   // Queue pointers and scheduling state.
   logic [QAW-1:0]     head_ff [2];
   logic [QAW-1:0]     head_in [2];
   logic [CW-1:0]      cnt_ff [2];
   logic [CW-1:0]      cnt_in [2];
   logic [1:0]         busy_ff, busy_in;
   logic [SLOT_COUNT-1:0] slot_free_ff, slot_free_in;
   logic [1:0]         moved_ff, moved_in;
   logic [7:0]         idle_ff, idle_in;
   logic               aff_ff, aff_in;

   // Fetched back entries.
   queue_entry_type    qdat_ff [2];
   queue_entry_type    qdat_in [2];
   job_entry_type      je0_ff, je0_in;

   // Result buffer and output register.
   result_type         res_ff [3];
   result_type         res_in [3];
   logic [1:0]         res_cnt_ff, res_cnt_in;
   logic [1:0]         res_idx_ff, res_idx_in;
   result_type         out_ff, out_in;
   logic               out_last_ff, out_last_in;
   logic               out_valid_ff, out_valid_in;

   // Memory ports.
   logic               qwe [2];
   logic [QAW-1:0]     qwaddr [2];
   queue_entry_type    qwdata;
   logic               qre;
   logic [QAW-1:0]     back_idx [2];
   logic [QAW-1:0]     push_idx [2];
   queue_entry_type    qrdata [2];
   logic               jwe;
   logic [JIW-1:0]     jwaddr;
   job_entry_type      jwdata;
   logic               jre;
   logic [JIW-1:0]     jraddr;
   job_entry_type      jrdata;

   // Scheduling decision.
   logic               nz [2];
   logic               pick_take;
   logic               pick_q;
   logic [1:0]         pick_moved;
   logic               pick_lw;
   job_entry_type      sel_je;
   queue_entry_type    sel_qe;
   logic               claim_go;
   logic               claim_ok;
   logic [SIW-1:0]     claim_idx;
   logic               emit_en;
   result_type         emit_data;
   logic               out_load;

   twltd_ram #(.WIDTH($bits(queue_entry_type)), .DEPTH(QUEUE_DEPTH)) u_queue0 (
      .clock  (clock),
      .wr_en  (qwe[0]),
      .wr_addr(qwaddr[0]),
      .wr_data(qwdata),
      .rd_en  (qre),
      .rd_addr(back_idx[0]),
      .rd_data(qrdata[0])
   );

   twltd_ram #(.WIDTH($bits(queue_entry_type)), .DEPTH(QUEUE_DEPTH)) u_queue1 (
      .clock  (clock),
      .wr_en  (qwe[1]),
      .wr_addr(qwaddr[1]),
      .wr_data(qwdata),
      .rd_en  (qre),
      .rd_addr(back_idx[1]),
      .rd_data(qrdata[1])
   );

   twltd_ram #(.WIDTH($bits(job_entry_type)), .DEPTH(JOB_COUNT)) u_jobs (
      .clock  (clock),
      .wr_en  (jwe),
      .wr_addr(jwaddr),
      .wr_data(jwdata),
      .rd_en  (jre),
      .rd_addr(jraddr),
      .rd_data(jrdata)
   );

   // Back and push positions of each circular queue.
   always_comb begin
      logic [CW-1:0] bsum;
      logic [CW-1:0] psum;
      for (int q = 0; q < 2; q++) begin
         bsum = CW'(head_ff[q]) + cnt_ff[q] - CW'(1);
         if (bsum >= QD_C) bsum = bsum - QD_C;
         psum = CW'(head_ff[q]) + cnt_ff[q];
         if (psum >= QD_C) psum = psum - QD_C;
         back_idx[q] = bsum[QAW-1:0];
         push_idx[q] = psum[QAW-1:0];
         nz[q]       = (cnt_ff[q] != '0);
      end
   end

   // Policy selection for the worker named by the command.
   always_comb begin
      job_entry_type je [2];
      logic          last_q [2];
      logic          w;
      logic          o;
      logic [1:0]    mine;
      logic          m;
      logic          m0;
      logic          tk;
      logic          qs;
      je[0] = je0_ff;
      je[1] = jrdata;
      for (int q = 0; q < 2; q++) begin
         last_q[q] = ({1'b0, qdat_ff[q].layer} + 8'd1) == {1'b0, je[q].layers};
      end
      w    = cmd.worker;
      o    = !cmd.worker;
      mine = w ? OWNER_W1 : OWNER_W0;
      m    = moved_ff[0];
      m0   = moved_ff[1];
      tk   = 1'b0;
      qs   = 1'b0;
      pick_lw = 1'b0;
      case (policy_mode)
         POL_ADAPTIVE, POL_LAYERWISE, POL_AFFINITY: begin
            if (policy_mode == POL_AFFINITY || (policy_mode == POL_ADAPTIVE && aff_ff)) begin
               // Affinity: own job on the other queue, then own queue, then other queue.
               if (nz[o] && je[o].owner == mine) begin
                  tk = 1'b1;
                  qs = o;
               end else if (nz[w] && (je[w].owner == OWNER_NONE || je[w].owner == mine)) begin
                  tk = 1'b1;
                  qs = w;
               end else if (nz[o] && (je[o].owner == OWNER_NONE || je[o].owner == mine)) begin
                  tk = 1'b1;
                  qs = o;
               end
            end else begin
               // Layerwise moving: a job may follow the worker that took its first layer.
               pick_lw = 1'b1;
               if (m0) begin
                  if (!w) begin
                     if (nz[0]) begin
                        tk = 1'b1;
                        qs = 1'b0;
                        m0 = 1'b0;
                     end else if (nz[1]) begin
                        tk = 1'b1;
                        qs = 1'b1;
                     end
                  end else if (nz[1]) begin
                     tk = 1'b1;
                     qs = 1'b1;
                     if (last_q[1]) m0 = 1'b0;
                  end
               end else if (m) begin
                  if (nz[0] && qdat_ff[0].layer != '0) begin
                     tk = 1'b1;
                     qs = 1'b0;
                     if (last_q[0]) m = 1'b0;
                  end
               end else begin
                  if (nz[w]) begin
                     tk = 1'b1;
                     qs = w;
                  end else if (w && busy_ff[0] && nz[0] && qdat_ff[0].layer == '0) begin
                     tk = 1'b1;
                     qs = 1'b0;
                     if (je[0].layers > LAYER_W'(1)) m = 1'b1;
                  end else if (!w && nz[1] && qdat_ff[1].layer == '0 && busy_ff[1]) begin
                     tk = 1'b1;
                     qs = 1'b1;
                     if (je[1].layers > LAYER_W'(1)) m0 = 1'b1;
                  end
               end
            end
         end
         POL_PARITY: begin
            // First queue whose back layer parity matches the worker.
            if (nz[0] && qdat_ff[0].layer[0] == w) begin
               tk = 1'b1;
               qs = 1'b0;
            end else if (nz[1] && qdat_ff[1].layer[0] == w) begin
               tk = 1'b1;
               qs = 1'b1;
            end
         end
         default: begin
            // Fixed per model, also for the unused mode codes.
            tk = nz[w];
            qs = w;
         end
      endcase
      pick_take  = tk;
      pick_q     = qs;
      pick_moved = {m0, m};
      sel_je     = je[qs];
      sel_qe     = qdat_ff[qs];
   end

   // First free slot in the half that belongs to the selected job's model.
   always_comb begin
      claim_go  = (sel_qe.layer == '0);
      claim_ok  = 1'b0;
      claim_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (slot_free_ff[i] && (sel_je.model ? (i >= HALF) : (i < SLOT_COUNT - HALF))) begin
            claim_ok  = 1'b1;
            claim_idx = SIW'(i);
         end
      end
   end

   // Next-state logic of the datapath.
   always_comb begin
      logic [LAYER_W-1:0] tot;
      logic [LAYER_W-1:0] nl;
      logic               qm;
      job_entry_type      upd;
      op_in        = op_ff;
      job_in       = job_ff;
      msel_in      = msel_ff;
      total_in     = total_ff;
      dw_in        = dw_ff;
      dl_in        = dl_ff;
      rs_in        = rs_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      busy_in      = busy_ff;
      slot_free_in = slot_free_ff;
      moved_in     = moved_ff;
      idle_in      = idle_ff;
      aff_in       = aff_ff;
      qdat_in      = qdat_ff;
      je0_in       = je0_ff;
      res_in       = res_ff;
      res_cnt_in   = res_cnt_ff;
      res_idx_in   = res_idx_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;
      qwe[0]       = 1'b0;
      qwe[1]       = 1'b0;
      qwaddr[0]    = push_idx[0];
      qwaddr[1]    = push_idx[1];
      qwdata       = '0;
      qre          = 1'b0;
      jwe          = 1'b0;
      jwaddr       = job_ff;
      jwdata       = '0;
      jre          = 1'b0;
      jraddr       = job_ff;
      emit_en      = 1'b0;
      emit_data    = '0;
      tot          = total_ff;
      nl           = LAYER_W'(dl_ff) + LAYER_W'(1);
      qm           = 1'b0;
      upd          = sel_je;

      // Capture a new event.
      if (cmd.accept) begin
         op_in      = op_type'(req_operation);
         job_in     = job_index(req_job_handle);
         msel_in    = req_model_sel;
         total_in   = req_layer_total;
         dw_in      = req_done_worker;
         dl_in      = req_done_layer;
         rs_in      = req_ready_slot;
         res_cnt_in = '0;
         res_idx_in = '0;
      end

      // Job entry fetch for a layer done event.
      if (cmd.ev_read) begin
         jre    = 1'b1;
         jraddr = job_ff;
      end

      // Apply the event.
      if (cmd.ev_exec) begin
         case (op_ff)
            OP_ARRIVAL: begin
               if (tot == '0) tot = LAYER_W'(1);
               if (32'(tot) > MAX_LAYERS) tot = LAYER_W'(MAX_LAYERS);
               if (cnt_ff[msel_ff] == QD_C) begin
                  emit_en         = 1'b1;
                  emit_data.kind  = KIND_DROP;
                  emit_data.job   = 6'(job_ff);
               end else begin
                  head_in[msel_ff] = (head_ff[msel_ff] == '0) ? QAW'(QUEUE_DEPTH - 1)
                                                              : head_ff[msel_ff] - QAW'(1);
                  cnt_in[msel_ff]  = cnt_ff[msel_ff] + CW'(1);
                  qwe[msel_ff]     = 1'b1;
                  qwaddr[msel_ff]  = head_in[msel_ff];
                  qwdata.job       = job_ff;
                  qwdata.layer     = '0;
                  jwe              = 1'b1;
                  jwaddr           = job_ff;
                  jwdata.layers    = tot;
                  jwdata.model     = msel_ff;
                  jwdata.owner     = OWNER_NONE;
               end
            end
            OP_DONE: begin
               busy_in[dw_ff] = 1'b0;
               qm = jrdata.model;
               if (nl < jrdata.layers) begin
                  if (cnt_ff[qm] == QD_C) begin
                     emit_en         = 1'b1;
                     emit_data.kind  = KIND_DROP;
                     emit_data.job   = 6'(job_ff);
                     emit_data.layer = nl[5:0];
                  end else begin
                     cnt_in[qm]   = cnt_ff[qm] + CW'(1);
                     qwe[qm]      = 1'b1;
                     qwaddr[qm]   = push_idx[qm];
                     qwdata.job   = job_ff;
                     qwdata.layer = nl;
                  end
               end else begin
                  emit_en           = 1'b1;
                  emit_data.kind    = KIND_REFILL;
                  emit_data.job     = 6'(job_ff);
                  emit_data.slot    = jrdata.slot_ok ? 4'(jrdata.slot) : 4'd0;
                  emit_data.slot_ok = jrdata.slot_ok;
               end
            end
            OP_SLOT: begin
               if (32'(rs_ff) < SLOT_COUNT) slot_free_in[SIW'(rs_ff)] = 1'b1;
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
      end

      // Start of a scheduling pass: adaptive idle pass count and mode choice.
      if (cmd.sch_init) begin
         if (policy_mode == POL_ADAPTIVE && busy_ff == 2'b00 && idle_ff < IDLE_MAX) begin
            idle_in = idle_ff + 8'd1;
         end
         aff_in = (policy_mode == POL_ADAPTIVE) && (idle_in > idle_threshold);
      end

      // Back entries of both queues, then their two job entries in turn.
      if (cmd.q_read) begin
         qre = 1'b1;
      end
      if (cmd.j0_read) begin
         qdat_in = qrdata;
         jre     = 1'b1;
         jraddr  = qrdata[0].job;
      end
      if (cmd.j1_read) begin
         je0_in = jrdata;
         jre    = 1'b1;
         jraddr = qdat_ff[1].job;
      end

      // Dispatch to the current worker.
      if (cmd.w_exec) begin
         if (pick_lw) moved_in = pick_moved;
         if (pick_take) begin
            cnt_in[pick_q] = cnt_ff[pick_q] - CW'(1);
            upd.owner = cmd.worker ? OWNER_W1 : OWNER_W0;
            if (claim_go) begin
               upd.slot    = claim_ok ? claim_idx : '0;
               upd.slot_ok = claim_ok;
               if (claim_ok) slot_free_in[claim_idx] = 1'b0;
            end
            jwe    = 1'b1;
            jwaddr = sel_qe.job;
            jwdata = upd;
            busy_in[cmd.worker] = 1'b1;
            emit_en             = 1'b1;
            emit_data.kind      = KIND_DISPATCH;
            emit_data.to_worker = cmd.worker;
            emit_data.job       = 6'(sel_qe.job);
            emit_data.layer     = sel_qe.layer[5:0];
            emit_data.slot      = upd.slot_ok ? 4'(upd.slot) : 4'd0;
            emit_data.slot_ok   = upd.slot_ok;
         end
      end

      // Append a result to the buffer.
      if (emit_en) begin
         res_in[res_cnt_ff] = emit_data;
         res_cnt_in         = res_cnt_ff + 2'd1;
      end

      // Move buffered results into the output register.
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (out_load) begin
         out_in       = res_ff[res_idx_ff];
         out_last_in  = (res_idx_ff + 2'd1) == res_cnt_ff;
         out_valid_in = 1'b1;
         res_idx_in   = res_idx_ff + 2'd1;
      end
   end

   assign out_load = cmd.drain && (res_idx_ff != res_cnt_ff) && (!out_valid_ff || !rsp_stall);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff[0]   <= '0;
         head_ff[1]   <= '0;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         busy_ff      <= 2'b00;
         slot_free_ff <= '0;
         moved_ff     <= 2'b00;
         idle_ff      <= 8'd0;
         aff_ff       <= 1'b0;
         res_cnt_ff   <= 2'd0;
         res_idx_ff   <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         busy_ff      <= busy_in;
         slot_free_ff <= slot_free_in;
         moved_ff     <= moved_in;
         idle_ff      <= idle_in;
         aff_ff       <= aff_in;
         res_cnt_ff   <= res_cnt_in;
         res_idx_ff   <= res_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      job_ff      <= job_in;
      msel_ff     <= msel_in;
      total_ff    <= total_in;
      dw_ff       <= dw_in;
      dl_ff       <= dl_in;
      rs_ff       <= rs_in;
      qdat_ff     <= qdat_in;
      je0_ff      <= je0_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign status.any_queued = nz[0] || nz[1];
   assign status.busy       = busy_ff;
   assign status.drain_done = (res_idx_ff == res_cnt_ff);

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_ff.kind;
   assign rsp_to_worker = out_ff.to_worker;
   assign rsp_out_job   = out_ff.job;
   assign rsp_out_layer = out_ff.layer;
   assign rsp_out_slot  = out_ff.slot;
   assign rsp_slot_ok   = out_ff.slot_ok;
   assign rsp_last      = out_last_ff;

   `TWLTD_ASSERT_IMP(a_pop_nonempty, clock, reset, cmd.w_exec && pick_take, cnt_ff[pick_q] != '0, "pop from an empty queue")
   `TWLTD_ASSERT_NEXT(a_dispatch_busy, clock, reset, cmd.w_exec && pick_take, busy_ff[$past(cmd.worker)], "dispatched worker not busy")
   `TWLTD_ASSERT_IMP(a_claim_free, clock, reset, cmd.w_exec && pick_take && claim_go && claim_ok, slot_free_ff[claim_idx], "claimed slot was not free")

endmodule

[rtl/two_worker_layer_task_dispatcher.sv]
// Two-worker layer task dispatcher, one event per input transfer, up to three results.
// Each event is read and applied, then scheduled, then its results are drained; the next event
// is accepted only after the drain. With tasks queued, each idle worker adds a pick step, the
// back reads of both queues, then the two job table reads on its one port and the dispatch, and
// each busy worker adds only a pick step. Synchronous active-high reset: queues empty, workers
// idle, all slots taken, adaptive mode, threshold 20; no clearing pass.
module two_worker_layer_task_dispatcher
   import twltd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int JOB_COUNT   = JOB_COUNT_DEF,
   parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
   parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [5:0]  req_job_handle,
   input  logic        req_model_sel,
   input  logic [6:0]  req_layer_total,
   input  logic        req_done_worker,
   input  logic [5:0]  req_done_layer,
   input  logic [3:0]  req_ready_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic        rsp_to_worker,
   output logic [5:0]  rsp_out_job,
   output logic [5:0]  rsp_out_layer,
   output logic [3:0]  rsp_out_slot,
   output logic        rsp_slot_ok,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cmd_type    cmd;
   status_type status;
   logic [2:0] policy_mode;
   logic [7:0] idle_threshold;

   twltd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .policy_mode   (policy_mode),
      .idle_threshold(idle_threshold)
   );

   twltd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   twltd_dpath #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .JOB_COUNT  (JOB_COUNT),
      .MAX_LAYERS (MAX_LAYERS),
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_operation),
      .req_job_handle (req_job_handle),
      .req_model_sel  (req_model_sel),
      .req_layer_total(req_layer_total),
      .req_done_worker(req_done_worker),
      .req_done_layer (req_done_layer),
      .req_ready_slot (req_ready_slot),
      .policy_mode    (policy_mode),
      .idle_threshold (idle_threshold),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_to_worker  (rsp_to_worker),
      .rsp_out_job    (rsp_out_job),
      .rsp_out_layer  (rsp_out_layer),
      .rsp_out_slot   (rsp_out_slot),
      .rsp_slot_ok    (rsp_slot_ok),
      .rsp_last       (rsp_last)
   );

endmodule
